[src/pcc_pkg.sv]
// ----------------------------------------------------------------------------
// pcc_pkg
// Types and constants shared by the prefix-code codec modules.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned ENTRY_W = 29;
  localparam int unsigned PAIR_W  = 58;
  localparam int unsigned NPAIRS  = 4;

  localparam logic [2:0] REG_DIRECTION = 3'd0;
  localparam logic [2:0] REG_PAIR_A    = 3'd1;
  localparam logic [2:0] REG_PAIR_B    = 3'd2;
  localparam logic [2:0] REG_PAIR_C    = 3'd3;
  localparam logic [2:0] REG_PAIR_D    = 3'd4;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_SYMBOL = 2'd1;
  localparam logic [1:0] STAT_NO_MATCH  = 2'd2;
  localparam logic [1:0] STAT_TRAILING  = 2'd3;

  localparam logic DIR_ENCODE = 1'b0;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  symbol;
  } entry_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             code_bit;
    logic             message_end;
  } in_word_t;

  typedef struct packed {
    logic             out_bit;
    logic [SYM_W-1:0] out_symbol;
    logic [1:0]       status;
    logic             last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [2:0]        index;
    logic [PAIR_W-1:0] wdata;
  } cfg_word_t;

  typedef struct packed {
    logic load;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic has_result;
    logic out_free;
    logic last_pending;
  } ctl_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctl_state_t;

endpackage

[src/pcc_chan_if.sv]
// ----------------------------------------------------------------------------
// pcc_chan_if
// Valid/ready channel carrying one word of a configurable type.
// ----------------------------------------------------------------------------
interface pcc_chan_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/pcc_ctrl.sv]
// ----------------------------------------------------------------------------
// pcc_ctrl
// Controller: takes one input word at a time and sequences its results.
// ----------------------------------------------------------------------------
module pcc_ctrl
  import pcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  ctl_status_t status,
  output ctl_cmd_t    cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid && status.has_result) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.last_pending) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

[src/pcc_datapath.sv]
// ----------------------------------------------------------------------------
// pcc_datapath
// Code table, table match, decoder accumulator, bit serializer and output
// register.
// ----------------------------------------------------------------------------
module pcc_datapath
  import pcc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES  = 8,
  parameter int unsigned MAX_CODE_LEN = 16
) (
  input  logic              clk,
  input  logic              rst,
  pcc_chan_if.sink          cfg,
  input  in_word_t          item_data,
  pcc_chan_if.source        result,
  input  ctl_cmd_t          cmd,
  output ctl_status_t       status
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_LEN);
  localparam logic [LEN_W-1:0] FULL_W  = LEN_W'(CODE_W);

  function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W:0] m;
    m = (17'd1 << len) - 17'd1;
    return (len >= FULL_W) ? '1 : m[CODE_W-1:0];
  endfunction

  logic              direction;
  logic [PAIR_W-1:0] pair_reg [NPAIRS];
  entry_t            entry [MAX_ENTRIES];

  logic [CODE_W-1:0] acc;
  logic [LEN_W-1:0]  cnt;
  logic [CODE_W-1:0] shreg;
  logic [LEN_W-1:0]  left;
  logic [SYM_W-1:0]  res_sym;
  logic [1:0]        res_status;
  logic              out_valid;
  out_word_t         out_reg;

  logic [CODE_W-1:0] acc_shift;
  logic [LEN_W-1:0]  cnt_inc;
  logic              enc_hit, dec_hit;
  entry_t            enc_ent, dec_ent;
  logic              has_result;
  logic [CODE_W-1:0] shreg_load;
  logic [LEN_W-1:0]  left_load;
  logic [SYM_W-1:0]  sym_load;
  logic [1:0]        status_load;

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      for (int i = 0; i < NPAIRS; i++) begin
        pair_reg[i] <= '0;
      end
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_DIRECTION: direction   <= cfg.data.wdata[0];
        REG_PAIR_A:    pair_reg[0] <= cfg.data.wdata;
        REG_PAIR_B:    pair_reg[1] <= cfg.data.wdata;
        REG_PAIR_C:    pair_reg[2] <= cfg.data.wdata;
        REG_PAIR_D:    pair_reg[3] <= cfg.data.wdata;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_entry
    assign entry[k] = entry_t'(pair_reg[k/2][(k%2)*ENTRY_W +: ENTRY_W]);
  end

  // table match, first entry wins
  assign acc_shift = {acc[CODE_W-2:0], item_data.code_bit};
  assign cnt_inc   = cnt + LEN_W'(1);

  always_comb begin
    enc_hit = 1'b0;
    dec_hit = 1'b0;
    enc_ent = '0;
    dec_ent = '0;
    for (int k = MAX_ENTRIES - 1; k >= 0; k--) begin
      if (entry[k].len != '0 && entry[k].len <= MAX_LEN) begin
        if (entry[k].symbol == item_data.symbol) begin
          enc_hit = 1'b1;
          enc_ent = entry[k];
        end
        if (entry[k].len == cnt_inc &&
            (entry[k].code & low_mask(cnt_inc)) == acc_shift) begin
          dec_hit = 1'b1;
          dec_ent = entry[k];
        end
      end
    end
  end

  always_comb begin
    has_result  = 1'b1;
    shreg_load  = '0;
    left_load   = LEN_W'(1);
    sym_load    = '0;
    status_load = STAT_OK;
    if (direction == DIR_ENCODE) begin
      if (enc_hit) begin
        left_load  = enc_ent.len;
        shreg_load = CODE_W'(enc_ent.code << (FULL_W - enc_ent.len));
      end else begin
        status_load = STAT_NO_SYMBOL;
      end
    end else if (dec_hit) begin
      sym_load = dec_ent.symbol;
    end else if (cnt_inc >= MAX_LEN) begin
      status_load = STAT_NO_MATCH;
    end else if (item_data.message_end) begin
      status_load = STAT_TRAILING;
    end else begin
      has_result = 1'b0;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else if (cmd.load && direction != DIR_ENCODE) begin
      if (has_result) begin
        acc <= '0;
        cnt <= '0;
      end else begin
        acc <= acc_shift;
        cnt <= cnt_inc;
      end
    end
  end

  // pending result serializer
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (cmd.load) begin
      left <= left_load;
    end else if (cmd.emit) begin
      left <= left - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg      <= shreg_load;
      res_sym    <= sym_load;
      res_status <= status_load;
    end else if (cmd.emit) begin
      shreg <= {shreg[CODE_W-2:0], 1'b0};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_reg.out_bit     <= shreg[CODE_W-1];
      out_reg.out_symbol  <= res_sym;
      out_reg.status      <= res_status;
      out_reg.last_of_run <= (left == LEN_W'(1));
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_reg;

  assign status.has_result   = has_result;
  assign status.out_free     = !out_valid || result.ready;
  assign status.last_pending = (left == LEN_W'(1));

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt < MAX_LEN)
    else $error("bit count reached max code length");

  a_acc_clean: assert property (@(posedge clk) disable iff (rst)
    (acc >> cnt) == '0)
    else $error("accumulator holds bits beyond bit count");

  a_emit_left: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> left != '0)
    else $error("emit with nothing pending");

  a_last_out: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && left == LEN_W'(1)) |=> (out_valid && out_reg.last_of_run))
    else $error("final result of a run not marked");

endmodule

[src/prefix_code_codec_top.sv]
// ----------------------------------------------------------------------------
// prefix_code_codec_top
// Table-driven prefix-code encoder and decoder.
//
// Channels: item (symbol, code_bit, message_end) in, result (out_bit,
// out_symbol, status, last_of_run) out, cfg (index, wdata) for the direction
// register and the four code table pair registers. All are valid/ready; a
// word moves at a clock edge where both are high. cfg is always ready.
// One item is worked on at a time. In encode mode an item gives one result
// word per code bit, most significant first; an unknown symbol gives one
// error word. In decode mode an item gives zero or one result word.
// The single-bit serializer loads a taken item and shifts its results into
// the output register, one per cycle while the receiver is not stalled. A
// result may wait in the output register while the next item is taken. A
// stalled receiver holds the serializer and the input stays not ready.
// Reset clears the table, the direction and the decoder accumulator.
// ----------------------------------------------------------------------------
module prefix_code_codec_top
  import pcc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES  = 8,
  parameter int unsigned MAX_CODE_LEN = 16
) (
  input  logic        clk,
  input  logic        rst,
  pcc_chan_if.sink    cfg,
  pcc_chan_if.sink    item,
  pcc_chan_if.source  result
);

  ctl_cmd_t    cmd;
  ctl_status_t status;
  logic        item_ready;

  assign item.ready = item_ready;

  pcc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  pcc_datapath #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_data (item.data),
    .result    (result),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
